// ===== hdl/ipv6_text_address_parser_defines.svh =====
// Assertion macros shared by the parser modules.
`ifndef IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define V6P_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v6p assertion failed");
`define V6P_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v6p assertion failed");
`else
`define V6P_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define V6P_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/v6p_pkg.sv =====
package v6p_pkg;

    localparam int GROUPS     = 8;
    localparam int GROUP_W    = 16;
    localparam int MAX_DIGITS = 4;
    localparam int COUNT_W    = 4;
    localparam int DIGIT_W    = 3;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_TERM  = 8'h00;

    typedef logic [GROUPS-1:0][GROUP_W-1:0] t_v6p_groups;

    typedef struct packed {
        logic               is_hex;
        logic [3:0]         nibble;
    } t_v6p_hex;

    // What the expansion stage needs to know about a finished string.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] gap_pos;
        logic               gap_seen;
        logic               bad;
    } t_v6p_final;

    function automatic t_v6p_hex v6p_hex(input logic [7:0] c);
        t_v6p_hex h;
        h.is_hex = 1'b1;
        h.nibble = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.nibble = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.nibble = 4'(c - 8'h61 + 8'd10);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.nibble = 4'(c - 8'h41 + 8'd10);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== hdl/v6p_parse.sv =====
`include "ipv6_text_address_parser_defines.svh"

module v6p_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_char_code,
    output v6p_pkg::t_v6p_groups o_groups,
    output v6p_pkg::t_v6p_final  o_final
);
    import v6p_pkg::*;

    logic [COUNT_W-1:0] r_group_count, n_group_count;
    logic [COUNT_W-1:0] r_gap_pos, n_gap_pos;
    logic               r_gap_seen, n_gap_seen;
    logic               r_expect_sep, n_expect_sep;
    logic               r_colon_pend, n_colon_pend;
    logic               r_lead_colon, n_lead_colon;
    logic [GROUP_W-1:0] r_digit_accum, n_digit_accum;
    logic [DIGIT_W-1:0] r_digit_count, n_digit_count;
    logic               r_at_start, n_at_start;
    logic               r_error, n_error;
    t_v6p_groups        r_store;

    logic               wr_en;
    logic               is_term;
    logic               is_colon;
    t_v6p_hex           hex;
    logic [COUNT_W-1:0] inc_count;

    assign is_term   = (i_char_code == CHAR_TERM);
    assign is_colon  = (i_char_code == CHAR_COLON);
    assign hex       = v6p_hex(i_char_code);
    assign inc_count = r_group_count + COUNT_W'(1);

    always_comb begin
        n_group_count = r_group_count;
        n_gap_pos     = r_gap_pos;
        n_gap_seen    = r_gap_seen;
        n_expect_sep  = r_expect_sep;
        n_colon_pend  = r_colon_pend;
        n_lead_colon  = r_lead_colon;
        n_digit_accum = r_digit_accum;
        n_digit_count = r_digit_count;
        n_at_start    = r_at_start;
        n_error       = r_error;
        wr_en         = 1'b0;
        if (i_fire) begin
            if (is_term) begin
                n_group_count = '0;
                n_gap_pos     = '0;
                n_gap_seen    = 1'b0;
                n_expect_sep  = 1'b0;
                n_colon_pend  = 1'b0;
                n_lead_colon  = 1'b0;
                n_digit_accum = '0;
                n_digit_count = '0;
                n_at_start    = 1'b1;
                n_error       = 1'b0;
            end else if (!r_error) begin
                n_at_start = 1'b0;
                if (r_expect_sep) begin
                    if (hex.is_hex) begin
                        if (r_digit_count >= DIGIT_W'(MAX_DIGITS)) begin
                            n_error = 1'b1;
                        end else begin
                            n_digit_accum = {r_digit_accum[GROUP_W-5:0], hex.nibble};
                            n_digit_count = r_digit_count + DIGIT_W'(1);
                        end
                    end else if (is_colon) begin
                        wr_en         = 1'b1;
                        n_group_count = inc_count;
                        n_digit_accum = '0;
                        n_digit_count = '0;
                        n_expect_sep  = 1'b0;
                        if (inc_count >= COUNT_W'(GROUPS)) begin
                            n_error = 1'b1;
                        end else begin
                            n_colon_pend = 1'b1;
                        end
                    end else begin
                        n_error = 1'b1;
                    end
                end else if (r_colon_pend || r_lead_colon) begin
                    n_colon_pend = 1'b0;
                    if (is_colon) begin
                        if (r_gap_seen) begin
                            n_error = 1'b1;
                        end else begin
                            n_gap_seen   = 1'b1;
                            n_gap_pos    = r_group_count;
                            n_lead_colon = 1'b0;
                        end
                    end else if (hex.is_hex && !r_lead_colon) begin
                        n_digit_accum = GROUP_W'(hex.nibble);
                        n_digit_count = DIGIT_W'(1);
                        n_expect_sep  = 1'b1;
                    end else begin
                        n_error = 1'b1;
                    end
                end else begin
                    // Start of the string, or just after a double colon.
                    if (hex.is_hex) begin
                        n_digit_accum = GROUP_W'(hex.nibble);
                        n_digit_count = DIGIT_W'(1);
                        n_expect_sep  = 1'b1;
                    end else if (is_colon && r_at_start) begin
                        n_lead_colon = 1'b1;
                    end else begin
                        n_error = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= '0;
            r_gap_pos     <= '0;
            r_gap_seen    <= 1'b0;
            r_expect_sep  <= 1'b0;
            r_colon_pend  <= 1'b0;
            r_lead_colon  <= 1'b0;
            r_digit_accum <= '0;
            r_digit_count <= '0;
            r_at_start    <= 1'b1;
            r_error       <= 1'b0;
        end else begin
            r_group_count <= n_group_count;
            r_gap_pos     <= n_gap_pos;
            r_gap_seen    <= n_gap_seen;
            r_expect_sep  <= n_expect_sep;
            r_colon_pend  <= n_colon_pend;
            r_lead_colon  <= n_lead_colon;
            r_digit_accum <= n_digit_accum;
            r_digit_count <= n_digit_count;
            r_at_start    <= n_at_start;
            r_error       <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_group_count[$clog2(GROUPS)-1:0]] <= r_digit_accum;
        end
    end

    // The group still being collected closes at the terminator; it is
    // folded in here instead of being written to the store.
    always_comb begin
        for (int k = 0; k < GROUPS; k++) begin
            if (r_expect_sep && (r_group_count == COUNT_W'(k))) begin
                o_groups[k] = r_digit_accum;
            end else begin
                o_groups[k] = r_store[k];
            end
        end
    end

    always_comb begin
        o_final.count    = r_group_count + COUNT_W'(r_expect_sep);
        o_final.gap_pos  = r_gap_pos;
        o_final.gap_seen = r_gap_seen;
        o_final.bad      = r_error
                        || (!r_expect_sep && (r_colon_pend || r_lead_colon))
                        || ((o_final.count < COUNT_W'(GROUPS)) && !r_gap_seen);
    end

    `V6P_ASSERT_IMPLY(a_digit_limit, i_clk, i_rst_n, 1'b1,
        r_digit_count <= DIGIT_W'(MAX_DIGITS))
    `V6P_ASSERT_IMPLY(a_idle_no_digits, i_clk, i_rst_n, !r_expect_sep,
        r_digit_count == '0)
    `V6P_ASSERT_NEXT(a_term_clears, i_clk, i_rst_n, i_fire && is_term,
        r_at_start && !r_error && !r_gap_seen)

endmodule

// ===== hdl/v6p_expand.sv =====
module v6p_expand (
    input  v6p_pkg::t_v6p_groups i_groups,
    input  v6p_pkg::t_v6p_final  i_final,
    output logic [63:0]          o_addr_upper,
    output logic [63:0]          o_addr_lower,
    output logic                 o_status
);
    import v6p_pkg::*;

    localparam int IDX_W = $clog2(GROUPS);

    logic [COUNT_W-1:0] zeros;
    logic [COUNT_W:0]   gap_end;
    t_v6p_groups        addr;

    assign zeros   = i_final.gap_seen ? (COUNT_W'(GROUPS) - i_final.count) : '0;
    assign gap_end = {1'b0, i_final.gap_pos} + {1'b0, zeros};

    // Groups before the gap stay put, the gap reads as zero, and the
    // groups after it shift right by the length of the run; a bad string reads as all zeros.
    always_comb begin
        for (int k = 0; k < GROUPS; k++) begin
            if (i_final.bad) begin
                addr[GROUPS-1-k] = '0;
            end else if (!i_final.gap_seen || (COUNT_W'(k) < i_final.gap_pos)) begin
                addr[GROUPS-1-k] = i_groups[k];
            end else if ((COUNT_W+1)'(k) < gap_end) begin
                addr[GROUPS-1-k] = '0;
            end else begin
                addr[GROUPS-1-k] = i_groups[IDX_W'(COUNT_W'(k) - zeros)];
            end
        end
    end

    assign o_addr_upper = addr[GROUPS-1:GROUPS/2];
    assign o_addr_lower = addr[GROUPS/2-1:0];
    assign o_status     = i_final.bad;

endmodule

// ===== hdl/ipv6_text_address_parser.sv =====
// Channel | Handshake                  | Payload
// in      | i_in_valid / o_in_stall    | i_char_code
// out     | o_out_valid / i_out_stall  | o_addr_upper, o_addr_lower, o_status
//
// One character is taken per cycle unless the input stalls; the parse state updates on the beat.
// The terminator beat loads the result register, visible from the next cycle.
// Reset is synchronous and active low and leaves the parser at string start.
// Input stalls only for a terminator beat while a result waits and the
// output side stalls; other characters keep flowing.
`include "ipv6_text_address_parser_defines.svh"

module ipv6_text_address_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_addr_upper,
    output logic [63:0] o_addr_lower,
    output logic        o_status
);
    import v6p_pkg::*;

    logic         in_fire;
    logic         term_fire;
    logic         out_fire;
    t_v6p_groups  groups;
    t_v6p_final   fin;
    logic [63:0]  res_upper;
    logic [63:0]  res_lower;
    logic         res_status;

    logic         r_out_valid;
    logic [63:0]  r_addr_upper;
    logic [63:0]  r_addr_lower;
    logic         r_status;

    assign o_in_stall = r_out_valid && i_out_stall && (i_char_code == CHAR_TERM);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign term_fire  = in_fire && (i_char_code == CHAR_TERM);
    assign out_fire   = r_out_valid && !i_out_stall;

    v6p_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_char_code (i_char_code),
        .o_groups    (groups),
        .o_final     (fin)
    );

    v6p_expand u_expand (
        .i_groups     (groups),
        .i_final      (fin),
        .o_addr_upper (res_upper),
        .o_addr_lower (res_lower),
        .o_status     (res_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (term_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_fire) begin
            r_addr_upper <= res_upper;
            r_addr_lower <= res_lower;
            r_status     <= res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_addr_upper = r_addr_upper;
    assign o_addr_lower = r_addr_lower;
    assign o_status     = r_status;

    `V6P_ASSERT_NEXT(a_term_gives_beat, i_clk, i_rst_n, term_fire, o_out_valid)
    `V6P_ASSERT_NEXT(a_waiting_kept, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid)
    `V6P_ASSERT_IMPLY(a_error_zero_addr, i_clk, i_rst_n, o_out_valid && o_status,
        (o_addr_upper == '0) && (o_addr_lower == '0))

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import v6p_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int RANDOM_CHARS   = 1250;
    localparam int MAX_GAP        = 12;

    typedef logic [7:0] t_char_q[$];

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
        logic        status;
    } t_addr_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_addr_upper;
    logic [63:0] o_addr_lower;
    logic        o_status;

    ipv6_text_address_parser u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_addr_upper (o_addr_upper),
        .o_addr_lower (o_addr_lower),
        .o_status     (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Parser state mirrored by the predictor.
    logic [15:0] grp_mem [GROUPS];
    logic [3:0]  n_groups;
    logic [3:0]  zrun_at;
    logic        zrun_seen;
    logic        in_group;
    logic        sep_pending;
    logic        lead_colon;
    logic [15:0] acc;
    logic [2:0]  ndig;
    logic        fresh;
    logic        failed;

    t_addr_result pending_addrs[$];
    t_addr_result got_addr;
    t_addr_result want_addr;

    int  mismatches      = 0;
    int  results_checked = 0;
    int  strings_sent    = 0;
    int  strings_bad     = 0;
    int  chars_sent      = 0;
    int  hold_requests   = 0;
    int  hold_served     = 0;
    int  hold_left       = 0;
    int  out_wait        = 0;
    int  quiet_cycles    = 0;
    bit  no_gaps         = 1'b0;

    function automatic void reset_parser();
        n_groups    = '0;
        zrun_at     = '0;
        zrun_seen   = 1'b0;
        in_group    = 1'b0;
        sep_pending = 1'b0;
        lead_colon  = 1'b0;
        acc         = '0;
        ndig        = '0;
        fresh       = 1'b1;
        failed      = 1'b0;
    endfunction

    // Nibble value of a hex digit in either case, or -1.
    function automatic int nibble_of(logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return int'(c - 8'h30);
        if (c inside {[8'h61:8'h66]}) return int'(c - 8'h61) + 10;
        if (c inside {[8'h41:8'h46]}) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void close_group();
        grp_mem[n_groups[2:0]] = acc;
        n_groups = n_groups + 4'd1;
        acc      = '0;
        ndig     = '0;
        in_group = 1'b0;
    endfunction

    function automatic void open_group(int v);
        acc      = 16'(v);
        ndig     = 3'd1;
        in_group = 1'b1;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int   v;
        logic first;
        v = nibble_of(c);
        if (failed) return;
        first = fresh;
        fresh = 1'b0;
        if (in_group) begin
            if (v >= 0) begin
                if (ndig >= MAX_DIGITS) begin
                    failed = 1'b1;
                end else begin
                    acc  = {acc[11:0], 4'(v)};
                    ndig = ndig + 3'd1;
                end
            end else if (c == CHAR_COLON) begin
                close_group();
                if (n_groups >= GROUPS) failed = 1'b1;
                else sep_pending = 1'b1;
            end else begin
                failed = 1'b1;
            end
        end else if (sep_pending || lead_colon) begin
            sep_pending = 1'b0;
            if (c == CHAR_COLON) begin
                if (zrun_seen) begin
                    failed = 1'b1;
                end else begin
                    zrun_seen  = 1'b1;
                    zrun_at    = n_groups;
                    lead_colon = 1'b0;
                end
            end else if (v >= 0 && !lead_colon) begin
                open_group(v);
            end else begin
                failed = 1'b1;
            end
        end else if (v >= 0) begin
            open_group(v);
        end else if (c == CHAR_COLON && first) begin
            lead_colon = 1'b1;
        end else begin
            failed = 1'b1;
        end
    endfunction

    // Closes the string: expands the zero run and clears for the next text.
    function automatic t_addr_result finish_address();
        t_addr_result r;
        logic         bad;
        int           zeros;
        logic [15:0]  g;
        bad = failed;
        if (!bad) begin
            if (in_group) close_group();
            else if (sep_pending || lead_colon) bad = 1'b1;
        end
        if (!bad && n_groups < GROUPS && !zrun_seen) bad = 1'b1;
        r = '0;
        r.status = bad;
        if (!bad) begin
            zeros = zrun_seen ? GROUPS - int'(n_groups) : 0;
            for (int k = 0; k < GROUPS; k++) begin
                if (!zrun_seen || k < int'(zrun_at)) g = grp_mem[k];
                else if (k < int'(zrun_at) + zeros) g = '0;
                else g = grp_mem[k - zeros];
                if (k < 4) r.upper = {r.upper[47:0], g};
                else r.lower = {r.lower[47:0], g};
            end
        end
        reset_parser();
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        // Pick the letter case at random.
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic void append_group(ref t_char_q t);
        logic [15:0] v;
        int          nd;
        case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hffff;
            default: v = 16'($urandom);
        endcase
        nd = $urandom_range(1, 4);
        for (int d = nd - 1; d >= 0; d--) t.push_back(hex_char(v[4*d +: 4]));
    endfunction

    function automatic t_char_q well_formed_text();
        t_char_q t;
        logic    with_gap;
        int      shown;
        int      split;
        with_gap = $urandom_range(0, 1);
        shown    = with_gap ? $urandom_range(0, GROUPS) : GROUPS;
        split    = $urandom_range(0, shown);
        for (int i = 0; i < shown; i++) begin
            if (with_gap && i == split) begin
                t.push_back(CHAR_COLON);
                t.push_back(CHAR_COLON);
            end else if (i > 0) begin
                t.push_back(CHAR_COLON);
            end
            append_group(t);
        end
        if (with_gap && split == shown) begin
            t.push_back(CHAR_COLON);
            t.push_back(CHAR_COLON);
        end
        return t;
    endfunction

    function automatic void corrupt_text(ref t_char_q t);
        int pos;
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 3))
            0: t[pos] = 8'($urandom_range(1, 255));
            1: t.insert(pos, 8'($urandom_range(1, 255)));
            2: t.delete(pos);
            default: t.insert(pos, CHAR_COLON);
        endcase
    endfunction

    function automatic t_char_q noise_text();
        t_char_q t;
        int      len;
        len = $urandom_range(0, 10);
        repeat (len) begin
            case ($urandom_range(0, 2))
                0: t.push_back(hex_char(4'($urandom)));
                1: t.push_back(CHAR_COLON);
                default: t.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        return t;
    endfunction

    function automatic t_char_q text_of(string s);
        t_char_q t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        chars_sent++;
        if (c == CHAR_TERM) begin
            pending_addrs.push_back(finish_address());
            if (pending_addrs[$].status) strings_bad++;
        end else begin
            parse_char(c);
        end
    endtask

    task automatic send_text(input t_char_q t);
        foreach (t[i]) send_char(t[i]);
        send_char(CHAR_TERM);
        strings_sent++;
    endtask

    // Never returns without waiting on the clock, so valid is never lowered and
    // raised again in the same step.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_addrs.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input t_addr_result want,
                                 input t_addr_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch, %s: expected upper=%h lower=%h status=%b",
                     what, want.upper, want.lower, want.status);
            $display("          got      upper=%h lower=%h status=%b",
                     got.upper, got.lower, got.status);
        end
    endtask

    // Result side: per-result stall draw, plus the long hold when requested.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_addr.upper  = o_addr_upper;
            got_addr.lower  = o_addr_lower;
            got_addr.status = o_status;
            if (pending_addrs.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, got_addr);
            end else begin
                want_addr = pending_addrs.pop_front();
                results_checked++;
                if (got_addr.upper !== want_addr.upper ||
                    got_addr.lower !== want_addr.lower ||
                    got_addr.status !== want_addr.status) begin
                    flag_mismatch("address result", want_addr, got_addr);
                end
            end
            out_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end else if (o_out_valid && out_wait > 0) begin
            out_wait--;
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        i_out_stall <= (out_wait > 0) || (hold_left > 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat on either side for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Each special case on its own, waiting for its result before the next.
    task automatic test_directed_texts();
        string texts[$];
        texts = '{"", "::", ":", ":1", "::1", "1::", "ffff:FFFF:aBcD:0:9:a:F:1",
                  "0:0:0:0:0:0:0:0", "1:2:3::4:5:6:7:8", "12345::",
                  "1:2:3:4:5:6:7:8:9", "1::2::3", "1:::2", "1:2:", "1:2:3",
                  "1:g", "g1::", "::ffff:1.2.3.4"};
        foreach (texts[i]) begin
            send_text(text_of(texts[i]));
            wait_for_drain();
        end
        send_text('{8'h01});
        wait_for_drain();
        send_text('{8'hff, 8'h80, 8'h7f});
        wait_for_drain();
    endtask

    // The result side holds off while texts keep coming, so the parser has to
    // stall its input on a terminator beat.
    task automatic test_output_backlog();
        hold_requests++;
        no_gaps = 1'b1;
        repeat (8) send_text(well_formed_text());
        no_gaps = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_random_texts();
        t_char_q txt;
        int      sent;
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: txt = noise_text();
                1, 2: begin
                    txt = well_formed_text();
                    corrupt_text(txt);
                end
                default: txt = well_formed_text();
            endcase
            send_text(txt);
            sent += txt.size() + 1;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        reset_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_texts();
        test_output_backlog();
        test_random_texts();
        wait_for_drain();
        repeat (16) @(posedge i_clk);
        $display("sent %0d address texts in %0d character beats, %0d of them invalid",
                 strings_sent, chars_sent, strings_bad);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
